>>> rtl/core/utf8_to_cp437_transcoder_core_assert.svh
// ----------------------------------------------------------------------------
// utf8 to cp437 transcoder assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP437_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_CP437_TRANSCODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define UTC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("utc assertion failed");

// expression must never be true outside reset
`define UTC_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("utc forbidden condition seen");

`else

`define UTC_ASSERT(name, clk, rst_n, prop)
`define UTC_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, constants and decode functions of the utf8 to cp437 transcoder.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam int unsigned UtcQueueDepth = 4;

  localparam logic [7:0]  QMark      = 8'h3F;
  localparam logic [7:0]  CharS      = 8'h53;
  localparam logic [20:0] CodeMax    = 21'h10FFFF;
  localparam logic [20:0] SurrLo     = 21'h00D800;
  localparam logic [20:0] SurrHi     = 21'h00DFFF;
  localparam logic [20:0] CapSharpS  = 21'h001E9E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } utc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } utc_out_t;

  // one queue entry: num_q question marks, then tail bytes up to count
  typedef struct packed {
    logic [1:0] num_q;
    logic [7:0] tail;
    logic [2:0] count;
  } utc_cmd_t;

  typedef struct packed {
    logic [1:0] exp_cont;
    logic [1:0] seen_cont;
  } utc_stat_t;

  typedef enum logic [1:0] {
    LeadAscii = 2'd0,
    LeadMulti = 2'd1,
    LeadBad   = 2'd2
  } utc_lead_kind_e;

  typedef struct packed {
    utc_lead_kind_e kind;
    logic [1:0]     cnt;
    logic [4:0]     bits;
  } utc_lead_t;

  typedef struct packed {
    logic [7:0] code;
    logic       dup;
  } utc_map_t;

  function automatic utc_lead_t utc_lead(input logic [7:0] b);
    utc_lead_t r;
    r.kind = LeadBad;
    r.cnt  = 2'd0;
    r.bits = 5'd0;
    unique case (b) inside
      [8'h00:8'h7F]: r.kind = LeadAscii;
      [8'hC2:8'hDF]: begin
        r.kind = LeadMulti;
        r.cnt  = 2'd1;
        r.bits = b[4:0];
      end
      [8'hE0:8'hEF]: begin
        r.kind = LeadMulti;
        r.cnt  = 2'd2;
        r.bits = {1'b0, b[3:0]};
      end
      [8'hF0:8'hF4]: begin
        r.kind = LeadMulti;
        r.cnt  = 2'd3;
        r.bits = {2'b00, b[2:0]};
      end
      default: r.kind = LeadBad;
    endcase
    return r;
  endfunction

  function automatic utc_map_t utc_map(input logic [20:0] cp);
    utc_map_t r;
    r.code = QMark;
    r.dup  = 1'b0;
    if (cp <= 21'h7F) begin
      r.code = cp[7:0];
    end else begin
      unique case (cp)
        21'h0000C4: r.code = 8'h8E;
        21'h0000D6: r.code = 8'h99;
        21'h0000DC: r.code = 8'h9A;
        21'h0000E4: r.code = 8'h84;
        21'h0000F6: r.code = 8'h94;
        21'h0000FC: r.code = 8'h81;
        21'h0000DF: r.code = 8'hE1;
        CapSharpS: begin
          r.code = CharS;
          r.dup  = 1'b1;
        end
        default: r.code = QMark;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/core/utc_front.sv
// ----------------------------------------------------------------------------
// utc_front
// Sequence decoder: tracks the pending utf8 sequence and turns each byte into
// at most one output command for the queue (none when it gives no byte).
// ----------------------------------------------------------------------------
module utc_front import utc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  utc_in_t   in_item_i,
  output logic      in_stall_o,
  input  logic      q_full_i,
  output logic      q_push_o,
  output utc_cmd_t  q_cmd_o,
  output utc_stat_t stat_o
);

  logic [1:0]  exp_q, exp_d;
  logic [1:0]  seen_q, seen_d;
  logic [20:0] acc_q, acc_d;

  logic        accept;
  logic [7:0]  b;
  logic        eot;
  logic        is_cont;
  logic [1:0]  seen_inc;
  logic [20:0] acc_inc;
  logic [20:0] min_cp;
  logic        reject;
  utc_lead_t   lead;
  utc_map_t    mapped;
  logic [1:0]  num_q;
  logic        tail_v;
  logic [7:0]  tail_b;
  logic        dup;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full_i;
  assign b          = in_item_i.in_byte;
  assign eot        = in_item_i.end_of_text;
  assign is_cont    = (b[7:6] == 2'b10);
  assign seen_inc   = seen_q + 2'd1;
  assign acc_inc    = {acc_q[14:0], b[5:0]};
  assign lead       = utc_lead(b);
  assign mapped     = utc_map(acc_inc);

  always_comb begin
    case (exp_q)
      2'd2:    min_cp = 21'h000800;
      2'd3:    min_cp = 21'h010000;
      default: min_cp = 21'h000080;
    endcase
  end

  assign reject = (acc_inc < min_cp) || (acc_inc > CodeMax) ||
                  ((acc_inc >= SurrLo) && (acc_inc <= SurrHi));

  always_comb begin
    exp_d  = exp_q;
    seen_d = seen_q;
    acc_d  = acc_q;
    num_q  = 2'd0;
    tail_v = 1'b0;
    tail_b = QMark;
    dup    = 1'b0;
    if ((exp_q != 2'd0) && is_cont) begin
      if (seen_inc >= exp_q) begin
        // sequence complete
        tail_v = 1'b1;
        if (!reject) begin
          tail_b = mapped.code;
          dup    = mapped.dup;
        end
        exp_d  = 2'd0;
        seen_d = 2'd0;
        acc_d  = '0;
      end else if (eot) begin
        // truncated: lead and every continuation give a question mark
        num_q  = seen_inc;
        tail_v = 1'b1;
        exp_d  = 2'd0;
        seen_d = 2'd0;
        acc_d  = '0;
      end else begin
        seen_d = seen_inc;
        acc_d  = acc_inc;
      end
    end else begin
      // abandon any pending sequence, then decode this byte as a lead
      if (exp_q != 2'd0) begin
        num_q = seen_q + 2'd1;
      end
      exp_d  = 2'd0;
      seen_d = 2'd0;
      acc_d  = '0;
      if ((lead.kind == LeadMulti) && !eot) begin
        exp_d = lead.cnt;
        acc_d = {16'd0, lead.bits};
      end else begin
        tail_v = 1'b1;
        tail_b = (lead.kind == LeadAscii) ? b : QMark;
      end
    end
    if (eot) begin
      exp_d  = 2'd0;
      seen_d = 2'd0;
      acc_d  = '0;
    end
  end

  assign q_cmd_o.num_q = num_q;
  assign q_cmd_o.tail  = tail_b;
  assign q_cmd_o.count = {1'b0, num_q} + {2'b00, tail_v} + {2'b00, dup};
  assign q_push_o      = accept && (q_cmd_o.count != 3'd0);

  assign stat_o.exp_cont  = exp_q;
  assign stat_o.seen_cont = seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 2'd0;
      seen_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      acc_q  <= acc_d;
    end
  end

endmodule

>>> rtl/core/utc_fifo.sv
// ----------------------------------------------------------------------------
// utc_fifo
// Small command queue between the decoder and the byte emitter.
// ----------------------------------------------------------------------------
module utc_fifo import utc_pkg::*; #(
  parameter int unsigned Depth = UtcQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  utc_cmd_t push_cmd_i,
  input  logic     pop_i,
  output utc_cmd_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utc_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/utc_back.sv
// ----------------------------------------------------------------------------
// utc_back
// Byte emitter: expands the queue head command into output items, one a cycle
// while the receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module utc_back import utc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  utc_cmd_t head_i,
  input  logic     empty_i,
  output logic     pop_o,
  output logic     out_valid_o,
  output utc_out_t out_item_o,
  input  logic     out_stall_i
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  utc_out_t   out_item_q, out_item_d;
  logic       load;
  logic       last;

  assign load  = !empty_i && (!out_valid_q || !out_stall_i);
  assign last  = ({1'b0, idx_q} == (head_i.count - 3'd1));
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d         = 1'b1;
      out_item_d.out_byte = (idx_q < head_i.num_q) ? QMark : head_i.tail;
      out_item_d.run_last = last;
      idx_d               = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/utf8_to_cp437_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_cp437_transcoder_core
// Converts a utf8 byte stream into cp437 bytes.
// ----------------------------------------------------------------------------
// usage:
//   input channel: one utf8 byte per item with an end_of_text flag on the
//   final byte of a text. output channel: cp437 bytes, run_last set on the
//   last byte caused by one input item. both channels use valid and stall.
//   an input item is decoded and written to the command queue at the edge
//   that accepts it; the output register then loads its bytes from the
//   queue head. throughput: one input item per cycle as long as each item
//   gives at most one byte and the receiver does not stall. an item gives
//   0 to 4 bytes; the output register sends one byte a cycle while the
//   receiver does not stall. a command queue of QueueDepth entries absorbs
//   such bursts, and in_stall_o rises only while the queue is full. items
//   that give no byte use no queue slot. when the receiver stalls, the
//   output item holds and the queue fills behind it. reset clears the
//   pending sequence, the queue and the output.
// ----------------------------------------------------------------------------
`include "utf8_to_cp437_transcoder_core_assert.svh"

module utf8_to_cp437_transcoder_core import utc_pkg::*; #(
  parameter int unsigned QueueDepth = UtcQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  utc_in_t  in_item_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output utc_out_t out_item_o,
  input  logic     out_stall_i
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  utc_cmd_t  q_cmd;
  utc_cmd_t  q_head;
  utc_stat_t stat;

  utc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd),
    .stat_o     (stat)
  );

  utc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  utc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // a pending sequence never has all its continuations already counted
  `UTC_ASSERT(a_seen_below_exp, clk_i, rst_ni, (stat.exp_cont != 2'd0) |-> (stat.seen_cont < stat.exp_cont))
  `UTC_ASSERT_NEVER(a_seen_idle, clk_i, rst_ni, (stat.exp_cont == 2'd0) && (stat.seen_cont != 2'd0))
  // queued work reaches an empty output register in the next cycle
  `UTC_ASSERT(a_drain, clk_i, rst_ni, (!q_empty && !out_valid_o) |=> out_valid_o)
  // the bytes of one item leave without a gap
  `UTC_ASSERT(a_run_gapless, clk_i, rst_ni, (out_valid_o && !out_item_o.run_last) |=> out_valid_o)

endmodule
